@@ rtl/spca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spca_pkg: shared types and codes for the spin pair correlation accumulator
// Holds opcodes, status codes and the command beat passed from front to back.
// ----------------------------------------------------------------------------
package spca_pkg;
    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // sample count limit; the count register is 16 bits wide
    localparam int MAX_SAMPLES = 65535;

    // classified command handed to the back end
    typedef struct packed {
        logic [1:0]  op;
        logic        range_err;
        logic        swap;
        logic [31:0] spin_bits;
        logic [4:0]  idx_a;
        logic [4:0]  idx_b;
    } t_cmd;
endpackage
`default_nettype wire

@@ rtl/spca_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spca_front: command intake and classification
// Accepts commands, drops unused opcodes, range checks query indices and
// pushes classified beats into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module spca_front import spca_pkg::*; #(
    parameter int SPINS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_spin_bits,
    input  wire logic [4:0]  i_first_index,
    input  wire logic [4:0]  i_second_index,
    input  wire logic [5:0]  i_spins_in_use,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_pop
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_err;

    assign o_busy      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_start && !o_busy && (i_op != 2'd3);

    // index check against register and instantiated spin count
    always_comb begin
        w_err = ({1'b0, i_first_index} >= i_spins_in_use) ||
                ({1'b0, i_second_index} >= i_spins_in_use) ||
                (32'(i_first_index) >= 32'(SPINS)) ||
                (32'(i_second_index) >= 32'(SPINS));
    end

    // queue storage; indices kept ordered, swap marks a reversed query
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].op        <= i_op;
            r_q[r_wp].range_err <= w_err;
            r_q[r_wp].swap      <= (i_first_index > i_second_index);
            r_q[r_wp].spin_bits <= i_spin_bits;
            r_q[r_wp].idx_a     <= (i_first_index <= i_second_index) ?
                                   i_first_index : i_second_index;
            r_q[r_wp].idx_b     <= (i_first_index <= i_second_index) ?
                                   i_second_index : i_first_index;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/spca_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spca_divider: Q14 fraction by restoring division
// Computes floor(mag*16384/den) for mag <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spca_divider #(
    parameter int W = 34
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_go,
    input  wire logic [W-1:0] i_mag,
    input  wire logic [W-1:0] i_den,
    output logic              o_done,
    output logic [14:0]       o_q
);
    logic [W:0]   r_r;
    logic [W-1:0] r_d;
    logic [14:0]  r_q;
    logic [3:0]   r_k;
    logic         r_run;

    assign o_q = r_q;

    // one step: shift remainder, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_d <= i_den;
                r_k <= 4'd0;
                if (i_mag >= i_den) begin
                    r_q <= 15'd16384; o_done <= 1'b1;
                end else begin
                    r_r <= {1'b0, i_mag}; r_q <= 15'd0; r_run <= 1'b1;
                end
            end else if (r_run) begin
                if ({r_r[W-1:0], 1'b0} >= {1'b0, r_d}) begin
                    r_r <= {r_r[W-1:0], 1'b0} - {1'b0, r_d};
                    r_q <= {r_q[13:0], 1'b1};
                end else begin
                    r_r <= {r_r[W-1:0], 1'b0};
                    r_q <= {r_q[13:0], 1'b0};
                end
                r_k <= r_k + 4'd1;
                if (r_k == 4'd13) begin
                    r_run <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/spca_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spca_back: accumulation and query engine
// Updates spin sums, and pair sums by a read and a write per row; clears pair
// rows one row a cycle and answers queries via a shared iterative divider.
// ----------------------------------------------------------------------------
module spca_back import spca_pkg::*; #(
    parameter int SPINS       = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    output logic             o_valid,
    output logic [15:0]      o_mag_first,
    output logic [15:0]      o_mag_second,
    output logic [15:0]      o_pair_mean,
    output logic [15:0]      o_connected_corr,
    output logic [1:0]       o_status,
    output logic             o_samples_full
);
    localparam int RW  = (SPINS > 1) ? $clog2(SPINS) : 1;
    localparam int CW  = 16;
    localparam int SW  = 17;
    localparam int DW  = 2 * CW + 2;

    localparam logic [3:0] S_IDLE = 4'd0, S_ROW = 4'd1, S_CLR = 4'd2,
                           S_RD = 4'd3, S_RD2 = 4'd4, S_MUL = 4'd5,
                           S_D0 = 4'd6, S_D1 = 4'd7, S_D2 = 4'd8,
                           S_D3 = 4'd9, S_OUT = 4'd10, S_RINIT = 4'd11;

    logic [3:0]        r_st;
    logic [RW-1:0]     r_row;
    logic              r_row_done;
    logic [CW-1:0]     r_cnt;
    logic              r_sat;
    logic [SPINS-1:0]  r_bits;
    t_cmd              r_cmd;

    // pair memory: row a holds sums of pairs (a,b), lane b
    logic [SPINS*SW-1:0] r_mem [SPINS];
    logic [SPINS*SW-1:0] r_rd;
    logic [SW-1:0]       r_ssum [SPINS];
    logic [SW-1:0]       r_si, r_sj, r_p;
    logic [SPINS*SW-1:0] w_wr;

    logic [DW-1:0] r_pm, r_pr, r_nmag, r_den;
    logic          r_nneg;
    logic          r_go;
    logic [DW-1:0] r_dmag, r_dden;
    logic          w_done;
    logic [14:0]   w_q;

    function automatic logic [SW-1:0] f_abs(input logic [SW-1:0] v);
        f_abs = v[SW-1] ? (~v + SW'(1)) : v;
    endfunction

    function automatic logic [15:0] f_pack(input logic neg, input logic [14:0] q);
        f_pack = neg ? (16'd0 - {1'b0, q}) : {1'b0, q};
    endfunction

    // bit value of spin k, used for the spin sum update
    function automatic logic f_bit(input logic [SPINS-1:0] b, input int k);
        f_bit = b[k];
    endfunction

    // row update: lane b > row gets +1 if bits agree, -1 otherwise
    always_comb begin
        for (int b = 0; b < SPINS; b++) begin
            if (b > int'(r_row)) begin
                if (r_bits[b] == r_bits[r_row])
                    w_wr[b*SW +: SW] = r_rd[b*SW +: SW] + SW'(1);
                else
                    w_wr[b*SW +: SW] = r_rd[b*SW +: SW] - SW'(1);
            end else begin
                w_wr[b*SW +: SW] = r_rd[b*SW +: SW];
            end
        end
    end

    // memory port: at most one row read or one row written per cycle
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_CLR: r_mem[r_row] <= '0;
            S_ROW: if (r_row_done) r_mem[r_row] <= w_wr;
            default: ;
        endcase
        if (r_st == S_RINIT || (r_st == S_ROW && !r_row_done))
            r_rd <= r_mem[r_row];
        else if (r_st == S_RD)
            r_rd <= r_mem[r_cmd.idx_a];
    end

    spca_divider #(.W(DW)) u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_go (r_go),
        .i_mag (r_dmag), .i_den (r_dden), .o_done (w_done), .o_q (w_q)
    );

    assign o_cmd_pop = (r_st == S_IDLE) && i_cmd_valid;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_row <= '0; r_cnt <= '0; r_sat <= 1'b0;
            o_valid <= 1'b0; r_go <= 1'b0; r_row_done <= 1'b0;
            for (int k = 0; k < SPINS; k++) r_ssum[k] <= '0;
        end else begin
            o_valid <= 1'b0;
            r_go    <= 1'b0;
            case (r_st)
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd  <= i_cmd;
                    r_bits <= SPINS'(i_cmd.spin_bits);
                    r_row  <= '0;
                    case (i_cmd.op)
                        OP_ACC: begin
                            if (32'(r_cnt) >= 32'(MAX_SAMPLES)) begin
                                r_sat <= 1'b1;
                            end else begin
                                r_cnt <= r_cnt + CW'(1);
                                for (int k = 0; k < SPINS; k++)
                                    r_ssum[k] <= f_bit(SPINS'(i_cmd.spin_bits), k) ?
                                        r_ssum[k] + SW'(1) : r_ssum[k] - SW'(1);
                                r_st <= S_RINIT;
                            end
                        end
                        OP_CLEAR: begin
                            r_cnt <= '0; r_sat <= 1'b0;
                            for (int k = 0; k < SPINS; k++) r_ssum[k] <= '0;
                            r_st <= S_CLR;
                        end
                        OP_QUERY: r_st <= S_RD;
                        default: ;
                    endcase
                end
                S_RINIT: begin
                    r_row_done <= 1'b1; r_st <= S_ROW;
                end
                S_ROW: begin
                    if (r_row_done) begin
                        r_row_done <= 1'b0;
                        if (32'(r_row) == SPINS - 1) r_st <= S_IDLE;
                        else r_row <= r_row + RW'(1);
                    end else begin
                        r_row_done <= 1'b1;
                    end
                end
                S_CLR: begin
                    if (32'(r_row) == SPINS - 1) r_st <= S_IDLE;
                    else r_row <= r_row + RW'(1);
                end
                S_RD: begin
                    // first spin sum follows the query's own order
                    r_si <= r_cmd.swap ? r_ssum[r_cmd.idx_b] : r_ssum[r_cmd.idx_a];
                    r_sj <= r_cmd.swap ? r_ssum[r_cmd.idx_a] : r_ssum[r_cmd.idx_b];
                    if (r_cmd.range_err || r_cnt == '0) begin
                        o_valid <= 1'b1;
                        o_mag_first <= '0; o_mag_second <= '0;
                        o_pair_mean <= '0; o_connected_corr <= '0;
                        o_status <= r_cmd.range_err ? ST_RANGE : ST_EMPTY;
                        o_samples_full <= r_sat;
                        r_st <= S_IDLE;
                    end else begin
                        r_st <= S_RD2;
                    end
                end
                S_RD2: begin
                    if (r_cmd.idx_a == r_cmd.idx_b) r_p <= SW'(r_cnt);
                    else r_p <= r_rd[r_cmd.idx_b*SW +: SW];
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_pm   <= DW'(f_abs(r_p)) * DW'(r_cnt);
                    r_pr   <= DW'(f_abs(r_si)) * DW'(f_abs(r_sj));
                    r_den  <= DW'(r_cnt) * DW'(r_cnt);
                    r_dmag <= DW'(f_abs(r_si)); r_dden <= DW'(r_cnt);
                    r_go   <= 1'b1;
                    r_st   <= S_D0;
                end
                S_D0: begin
                    if (r_p[SW-1] != (r_si[SW-1] ^ r_sj[SW-1])) begin
                        r_nmag <= r_pm + r_pr; r_nneg <= r_p[SW-1];
                    end else if (r_pm >= r_pr) begin
                        r_nmag <= r_pm - r_pr; r_nneg <= r_p[SW-1];
                    end else begin
                        r_nmag <= r_pr - r_pm; r_nneg <= !r_p[SW-1];
                    end
                    if (w_done) begin
                        o_mag_first <= f_pack(r_si[SW-1], w_q);
                        r_dmag <= DW'(f_abs(r_sj)); r_go <= 1'b1; r_st <= S_D1;
                    end
                end
                S_D1: if (w_done) begin
                    o_mag_second <= f_pack(r_sj[SW-1], w_q);
                    r_dmag <= DW'(f_abs(r_p)); r_go <= 1'b1; r_st <= S_D2;
                end
                S_D2: if (w_done) begin
                    o_pair_mean <= f_pack(r_p[SW-1], w_q);
                    r_dmag <= r_nmag; r_dden <= r_den; r_go <= 1'b1; r_st <= S_D3;
                end
                S_D3: if (w_done) begin
                    o_connected_corr <= f_pack(r_nneg && r_nmag != '0, w_q);
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1; o_status <= ST_OK; o_samples_full <= r_sat;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/spin_pair_correlation_accumulator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spin_pair_correlation_accumulator_unit: spin means and pair correlations
// Accumulates binary spin states and answers pair statistics queries.
//
// channel   direction  handshake            payload
// command   in         start & !busy        op, spin_bits, first/second index
// result    out        o_valid (1 cycle)    mags, pair mean, corr, status, full
// config    in         i_cfg_valid&ready    spins_in_use
//
// Accumulate: the spin sums update, then each pair row is read and written
// back in turn. Clear: one memory row per cycle. Query: four divider passes;
// a pass skips its bit steps when the quotient is exactly +-1, and a rejected
// or empty query skips the divider. Reset runs a clear of all pair rows.
// A two-entry command queue lets commands arrive while the engine works; busy
// rises only when it is full. Results cannot be stalled.
// ----------------------------------------------------------------------------
module spin_pair_correlation_accumulator_unit import spca_pkg::*; #(
    parameter int SPINS       = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_spin_bits,
    input  wire logic [4:0]  i_first_index,
    input  wire logic [4:0]  i_second_index,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [5:0]  i_cfg_data,
    output logic             o_valid,
    output logic [15:0]      o_mag_first,
    output logic [15:0]      o_mag_second,
    output logic [15:0]      o_pair_mean,
    output logic [15:0]      o_connected_corr,
    output logic [1:0]       o_status,
    output logic             o_samples_full
);
    logic [5:0] r_spins_in_use;
    logic       w_cmd_valid, w_pop;
    t_cmd       w_cmd;

    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_spins_in_use <= 6'd32;
        else if (i_cfg_valid && o_cfg_ready) r_spins_in_use <= i_cfg_data;
    end

    spca_front #(.SPINS(SPINS)) u_front (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (start), .o_busy (busy),
        .i_op (i_op), .i_spin_bits (i_spin_bits),
        .i_first_index (i_first_index), .i_second_index (i_second_index),
        .i_spins_in_use (r_spins_in_use),
        .o_cmd_valid (w_cmd_valid), .o_cmd (w_cmd), .i_cmd_pop (w_pop)
    );

    spca_back #(.SPINS(SPINS)) u_back (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_cmd_valid (w_cmd_valid), .i_cmd (w_cmd), .o_cmd_pop (w_pop),
        .o_valid (o_valid), .o_mag_first (o_mag_first),
        .o_mag_second (o_mag_second), .o_pair_mean (o_pair_mean),
        .o_connected_corr (o_connected_corr), .o_status (o_status),
        .o_samples_full (o_samples_full)
    );
endmodule
`default_nettype wire
